// File: rtl/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/prds_pkg.sv
// ----------------------------------------------------------------------------
// prds_pkg
// Types and constants shared by the pairwise root distance sum block.
// ----------------------------------------------------------------------------
package prds_pkg;

    localparam int COORD_W        = 24;
    localparam int SUM_W          = 40;
    localparam int FRAC_W         = 16;
    localparam int MAX_POINTS_DEF = 64;
    // Root widths of the two square root pipelines.
    localparam int SQ1_RW         = COORD_W + 2;
    localparam int SQ2_RW         = (SQ1_RW + FRAC_W) / 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_point;
    } t_req;

    typedef struct packed {
        logic [SUM_W-1:0] distance_sum;
        logic             overflow_flag;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic idle;
        logic pend_zero;
    } t_back_stat;

endpackage

// File: rtl/prds_front.sv
// ----------------------------------------------------------------------------
// prds_front
// Accepts point requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module prds_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  prds_pkg::t_req  i_req,
    output logic            o_busy,
    input  logic            i_pop,
    output logic            o_q_vld,
    output prds_pkg::t_req  o_q_req
);
    import prds_pkg::*;

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    // A request is taken whenever the queue has room.
    assign o_busy  = (r_cnt == 2'd2);
    assign w_push  = i_start && !o_busy;
    assign o_q_vld = (r_cnt != 2'd0);
    assign w_pop   = i_pop && o_q_vld;
    assign o_q_req = r_mem[r_rp];

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

endmodule

// File: rtl/prds_sqrt.sv
// ----------------------------------------------------------------------------
// prds_sqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module prds_sqrt #(
    parameter int RW = prds_pkg::SQ1_RW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [2*RW-1:0] i_rad,
    output logic            o_vld,
    output logic [RW-1:0]   o_root
);
    import prds_pkg::*;

    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_rad  [RW];
    logic            r_vld  [RW];

    // Each stage brings down two radicand bits and decides one root bit.
    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic [RW+1:0]   w_rem_i;
        logic [RW-1:0]   w_root_i;
        logic [2*RW-1:0] w_rad_i;
        logic            w_vld_i;
        logic [RW+1:0]   w_cand;
        logic [RW+1:0]   w_trial;
        logic            w_ge;

        if (g == 0) begin : g_first
            assign w_rem_i  = '0;
            assign w_root_i = '0;
            assign w_rad_i  = i_rad;
            assign w_vld_i  = i_vld;
        end else begin : g_next
            assign w_rem_i  = r_rem[g-1];
            assign w_root_i = r_root[g-1];
            assign w_rad_i  = r_rad[g-1];
            assign w_vld_i  = r_vld[g-1];
        end

        assign w_cand  = {w_rem_i[RW-1:0], w_rad_i[2*RW-1 -: 2]};
        assign w_trial = {w_root_i, 2'b01};
        assign w_ge    = (w_cand >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_vld_i;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= w_ge ? (w_cand - w_trial) : w_cand;
            r_root[g] <= {w_root_i[RW-2:0], w_ge};
            r_rad[g]  <= {w_rad_i[2*RW-3:0], 2'b00};
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];

endmodule

// File: rtl/prds_back.sv
// ----------------------------------------------------------------------------
// prds_back
// Pairs each point with the stored points, sums twice the root of each
// distance and emits the total on the final point.
// ----------------------------------------------------------------------------
module prds_back #(
    parameter int MAX_POINTS = prds_pkg::MAX_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_vld,
    input  prds_pkg::t_req       i_q_req,
    output logic                 o_pop,
    output logic                 o_done,
    output prds_pkg::t_res       o_res,
    output prds_pkg::t_back_stat o_stat
);
    import prds_pkg::*;

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIF_W  = COORD_W + 1;
    localparam int SQ_W   = 2 * DIF_W;
    localparam int ADD_W  = SQ2_RW + 1;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [CNT_W-1:0]     r_pend;
    logic [SUM_W-1:0]     r_acc;
    logic                 r_dropped;
    logic [COORD_W-1:0]   r_x;
    logic [COORD_W-1:0]   r_y;
    logic                 r_last;
    logic                 r_done;
    t_res                 r_res;
    logic [2*COORD_W-1:0] r_store [MAX_POINTS];
    logic [2*COORD_W-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [DIF_W-1:0]     r_dx, r_dy;
    logic                 r_a_vld;
    logic [SQ_W-1:0]      r_sqx, r_sqy;
    logic                 r_b_vld;
    logic [SQ_W:0]        r_s;
    logic                 r_c_vld;

    logic                 w_issue;
    logic                 w_wr;
    logic                 w_emit;
    logic                 w_full;
    logic signed [DIF_W-1:0] w_dx, w_dy;
    logic [COORD_W-1:0]   w_ex, w_ey;
    logic                 w_s1_vld;
    logic [SQ1_RW-1:0]    w_s1_root;
    logic                 w_ret;
    logic [SQ2_RW-1:0]    w_s2_root;
    logic [ADD_W-1:0]     w_add;
    logic [SUM_W:0]       w_sum;

    assign w_full = (r_count == CNT_W'(MAX_POINTS));

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: take a point, issue one pair per cycle, wait for the pipe.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_pop   = 1'b0;
        w_issue = 1'b0;
        w_wr    = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_k = '0;
                if (i_q_vld) begin
                    o_pop   = 1'b1;
                    n_state = w_full ? S_FINISH : S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_k == r_count) begin
                    n_state = S_DRAIN;
                end else begin
                    w_issue = 1'b1;
                    n_k     = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_pend == '0) begin
                    w_wr    = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                w_emit  = r_last;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Latch the point being worked on.
    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (o_pop) begin
            r_x    <= i_q_req.x_coord;
            r_y    <= i_q_req.y_coord;
            r_last <= i_q_req.last_point;
        end
    end

    // Point store, registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_store[r_count[ADDR_W-1:0]] <= {r_y, r_x};
        end
        if (w_issue) begin
            r_rd_data <= r_store[r_k[ADDR_W-1:0]];
        end
    end

    // Signed coordinate differences.
    assign w_ex = r_rd_data[COORD_W-1:0];
    assign w_ey = r_rd_data[2*COORD_W-1:COORD_W];
    assign w_dx = $signed({r_x[COORD_W-1], r_x}) - $signed({w_ex[COORD_W-1], w_ex});
    assign w_dy = $signed({r_y[COORD_W-1], r_y}) - $signed({w_ey[COORD_W-1], w_ey});

    // Difference, square and sum stages.
    always_ff @(posedge i_clk) begin
        r_dx  <= w_dx[DIF_W-1] ? DIF_W'(-w_dx) : DIF_W'(w_dx);
        r_dy  <= w_dy[DIF_W-1] ? DIF_W'(-w_dy) : DIF_W'(w_dy);
        r_sqx <= r_dx * r_dx;
        r_sqy <= r_dy * r_dy;
        r_s   <= {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
            r_a_vld  <= r_rd_vld;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
        end
    end

    // Distance, then root of the distance in Q.8.
    prds_sqrt #(.RW(SQ1_RW)) u_sqrt_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_rad   ({1'b0, r_s}),
        .o_vld   (w_s1_vld),
        .o_root  (w_s1_root)
    );

    prds_sqrt #(.RW(SQ2_RW)) u_sqrt_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_s1_vld),
        .i_rad   ({w_s1_root, {FRAC_W{1'b0}}}),
        .o_vld   (w_ret),
        .o_root  (w_s2_root)
    );

    // Ordered pairs count twice, so add twice the root, saturating.
    assign w_add = {w_s2_root, 1'b0};
    assign w_sum = {1'b0, r_acc} + (SUM_W+1)'(w_add);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_dropped <= 1'b0;
            r_count   <= '0;
            r_pend    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_pend <= r_pend + CNT_W'(w_issue) - CNT_W'(w_ret);
            r_done <= w_emit;
            if (w_ret) begin
                r_acc <= w_sum[SUM_W] ? {SUM_W{1'b1}} : w_sum[SUM_W-1:0];
            end
            if (o_pop && w_full) begin
                r_dropped <= 1'b1;
            end
            if (w_wr) begin
                r_count <= r_count + 1'b1;
            end
            if (w_emit) begin
                r_acc     <= '0;
                r_dropped <= 1'b0;
                r_count   <= '0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_res.distance_sum  <= r_acc;
            r_res.overflow_flag <= r_dropped;
        end
    end

    assign o_done           = r_done;
    assign o_res            = r_res;
    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.pend_zero = (r_pend == '0);

endmodule

// File: rtl/pairwise_root_distance_sum_top.sv
// ----------------------------------------------------------------------------
// pairwise_root_distance_sum_top
// Sums twice the root of the distance over all pairs of a point set.
//
//   Channel   Handshake            Payload
//   request   i_start / o_busy     i_req  (x_coord, y_coord, last_point)
//   result    o_done (strobe)      o_res  (distance_sum, overflow_flag)
//
// One pair per cycle goes through a store read, difference, square and sum
// stages and two pipelined square roots of 26 and 21 stages. The point is
// stored once the pipe has drained. A point with an empty store issues no
// pairs and a dropped point is neither paired nor stored. Two requests may
// wait in the front queue while one is worked on. Reset is synchronous and
// clears count, sum and flag; the result strobe lasts one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pairwise_root_distance_sum_top #(
    parameter int MAX_POINTS = prds_pkg::MAX_POINTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  prds_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_done,
    output prds_pkg::t_res o_res
);
    import prds_pkg::*;

    logic       w_pop;
    logic       w_q_vld;
    t_req       w_q_req;
    t_back_stat w_stat;

    // Request queue.
    prds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .i_pop   (w_pop),
        .o_q_vld (w_q_vld),
        .o_q_req (w_q_req)
    );

    // Pairing and accumulation.
    prds_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (w_q_vld),
        .i_q_req (w_q_req),
        .o_pop   (w_pop),
        .o_done  (o_done),
        .o_res   (o_res),
        .o_stat  (w_stat)
    );

    // A result never follows another directly.
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    // A result is only given once every pair has been summed.
    `ASSERT_IMPLIES(a_done_drained, i_clk, i_rst_n, o_done, w_stat.pend_zero)
    // The queue is popped only by an idle back end.
    `ASSERT_IMPLIES(a_pop_idle, i_clk, i_rst_n, w_pop, w_stat.idle && w_q_vld)

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pairwise root distance sum block. Point sets
// are queued and driven with random idle bursts. A local model of the point
// store predicts each set total and dropped flag. The strobed results are
// checked in order against those predictions.
// ----------------------------------------------------------------------------
module testbench;
    import prds_pkg::*;

    localparam int STORE_DEPTH = MAX_POINTS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req = '0;
    logic o_busy;
    logic o_done;
    t_res o_res;

    t_req point_queue[$];
    t_res expected_totals[$];
    int   error_count = 0;
    int   idle_left = 0;
    int   stall_cycles = 0;
    bit   just_taken = 1'b0;

    // Local copy of the point store and running totals.
    longint          held_x[STORE_DEPTH];
    longint          held_y[STORE_DEPTH];
    int              held_count = 0;
    logic [SUM_W-1:0] running_sum = '0;
    logic            dropped = 1'b0;

    pairwise_root_distance_sum_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Truncated integer square root, bit by bit.
    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned acc;
        longint unsigned probe;
        acc = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= acc + probe) begin
                v = v - (acc + probe);
                acc = (acc >> 1) + probe;
            end else begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return acc;
    endfunction

    // Pair the new point with every held point and store it, or drop it when the store is full.
    task automatic take_point(input t_req p);
        longint px;
        longint py;
        longint dx;
        longint dy;
        longint unsigned span;
        longint unsigned root2;
        logic [SUM_W:0] total;
        t_res res;
        px = longint'(p.x_coord);
        py = longint'(p.y_coord);
        if (held_count >= STORE_DEPTH) begin
            dropped = 1'b1;
        end else begin
            for (int k = 0; k < held_count; k++) begin
                dx = px - held_x[k];
                dy = py - held_y[k];
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                span = int_root(longint'(dx * dx + dy * dy));
                root2 = 2 * int_root(span << 16);
                total = {1'b0, running_sum} + (SUM_W+1)'(root2);
                running_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
            end
            held_x[held_count] = px;
            held_y[held_count] = py;
            held_count++;
        end
        if (p.last_point) begin
            res.distance_sum = running_sum;
            res.overflow_flag = dropped;
            expected_totals.push_back(res);
            held_count = 0;
            running_sum = '0;
            dropped = 1'b0;
        end
    endtask

    // Accepted requests and strobed results, sampled at the rising edge.
    always @(posedge i_clk) begin
        just_taken <= i_rst_n && i_start && !o_busy;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                take_point(i_req);
                void'(point_queue.pop_front());
            end
            if (o_done) begin
                if (expected_totals.size() == 0) begin
                    $error("result with no set pending: sum %0d", o_res.distance_sum);
                    error_count++;
                end else begin
                    if (o_res.distance_sum !== expected_totals[0].distance_sum) begin
                        $error("distance_sum expected %0d got %0d",
                               expected_totals[0].distance_sum, o_res.distance_sum);
                        error_count++;
                    end
                    if (o_res.overflow_flag !== expected_totals[0].overflow_flag) begin
                        $error("overflow_flag expected %0d got %0d",
                               expected_totals[0].overflow_flag, o_res.overflow_flag);
                        error_count++;
                    end
                    void'(expected_totals.pop_front());
                end
            end
            if ((i_start && !o_busy) || o_done) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Request driver with random idle bursts, none near the end.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                i_start <= 1'b0;
            end else if ((!i_start || just_taken) && point_queue.size() > 300
                         && $urandom_range(7) == 0) begin
                idle_left <= $urandom_range(16);
                i_start <= 1'b0;
            end else if (point_queue.size() > 0) begin
                i_start <= 1'b1;
                i_req <= point_queue[0];
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    function automatic t_req make_point(input int xv, input int yv, input bit fin);
        t_req p;
        p.x_coord = xv[COORD_W-1:0];
        p.y_coord = yv[COORD_W-1:0];
        p.last_point = fin;
        return p;
    endfunction

    function automatic int rand_coord(input int style, input int centre);
        case (style)
            0: return int'($urandom_range(32'hFF_FFFF)) - 8388608;
            1: return centre + int'($urandom_range(511)) - 256;
            2: return $urandom_range(1) ? 8388607 : -8388608;
            default: return int'($urandom_range(32'h3_FFFF)) - 131072;
        endcase
    endfunction

    initial begin
        int total;
        int set_size;
        int style;
        int cx;
        int cy;
        // Directed sets: corner extremes, a lone point, repeated points, small offsets.
        point_queue.push_back(make_point(8388607, 8388607, 1'b0));
        point_queue.push_back(make_point(-8388608, -8388608, 1'b1));
        point_queue.push_back(make_point(0, 0, 1'b1));
        point_queue.push_back(make_point(-8388608, 8388607, 1'b0));
        point_queue.push_back(make_point(8388607, -8388608, 1'b0));
        point_queue.push_back(make_point(-8388608, 8388607, 1'b0));
        point_queue.push_back(make_point(8388607, 8388607, 1'b0));
        point_queue.push_back(make_point(-8388608, -8388608, 1'b1));
        point_queue.push_back(make_point(5, 5, 1'b0));
        point_queue.push_back(make_point(5, 5, 1'b0));
        point_queue.push_back(make_point(5, 5, 1'b1));
        point_queue.push_back(make_point(65536, 0, 1'b0));
        point_queue.push_back(make_point(0, 65536, 1'b0));
        point_queue.push_back(make_point(-1, -1, 1'b0));
        point_queue.push_back(make_point(1, 0, 1'b1));
        total = point_queue.size();
        // Random sets: mostly small, now and then past the store size.
        while (total < 2000) begin
            if ($urandom_range(24) == 0) set_size = $urandom_range(70, 60);
            else set_size = $urandom_range(12, 1);
            style = $urandom_range(3);
            cx = rand_coord(0, 0) / 2;
            cy = rand_coord(0, 0) / 2;
            for (int n = 0; n < set_size; n++) begin
                point_queue.push_back(make_point(rand_coord(style, cx),
                                                 rand_coord(style, cy),
                                                 n == set_size - 1));
            end
            total += set_size;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (point_queue.size() == 0 && expected_totals.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/prds_pkg.sv
rtl/prds_front.sv
rtl/prds_sqrt.sv
rtl/prds_back.sv
rtl/pairwise_root_distance_sum_top.sv
tb/testbench.sv
